// File: src/bilinear_texture_sampler_defines.svh
// assertion macros shared by the checker
`ifndef BILINEAR_TEXTURE_SAMPLER_DEFINES_SVH
`define BILINEAR_TEXTURE_SAMPLER_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define BTSMP_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("bilinear sampler check failed");

// implication checked at every clock edge out of reset
`define BTSMP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bilinear sampler check failed");

`endif

// File: src/btsmp_pkg.sv
package btsmp_pkg;

    localparam int DEF_MAX_WIDTH   = 256;
    localparam int DEF_MAX_HEIGHT  = 256;
    localparam int DEF_WEIGHT_BITS = 8;

    localparam int CFG_W      = 9;
    localparam int INDEX_W    = 16;
    localparam int CHAN_W     = 8;
    localparam int TEXEL_W    = 3 * CHAN_W;
    localparam int COORD_W    = 18;
    localparam int COORD_FRAC = 16;
    localparam int CLAMP_W    = COORD_FRAC + 1;
    localparam int OUT_W      = 16;

    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = CFG_W'(256);

    localparam logic CFG_TEX_WIDTH  = 1'b0;
    localparam logic CFG_TEX_HEIGHT = 1'b1;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [CLAMP_W-1:0] COORD_ONE = CLAMP_W'(65536);
    localparam logic [OUT_W-1:0]   OUT_MAX   = 16'hFF00;

    localparam int PIPE_LATENCY = 5;

endpackage

// File: src/btsmp_front.sv
module btsmp_front #(
    parameter int MAX_WIDTH  = btsmp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = btsmp_pkg::DEF_MAX_HEIGHT,
    parameter int ITEM_W     = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic                              i_command,
    input  logic [btsmp_pkg::INDEX_W-1:0]     i_texel_index,
    input  logic [btsmp_pkg::TEXEL_W-1:0]     i_texel,
    input  logic signed [btsmp_pkg::COORD_W-1:0] i_u_coord,
    input  logic signed [btsmp_pkg::COORD_W-1:0] i_v_coord,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]    i_size_x,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]   i_size_y,
    output logic                              o_push,
    output logic [ITEM_W-1:0]                 o_item
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int SCX = btsmp_pkg::CLAMP_W + XW;
    localparam int SCY = btsmp_pkg::CLAMP_W + YW;

    logic [btsmp_pkg::CLAMP_W-1:0] cu;
    logic [btsmp_pkg::CLAMP_W-1:0] cv;
    logic [XW-1:0]                 xm1;
    logic [YW-1:0]                 ym1;
    logic [SCX-1:0]                n_sc_x;
    logic [SCY-1:0]                n_sc_y;
    logic                          r_vld;
    logic [ITEM_W-1:0]             r_item;

    function automatic logic [btsmp_pkg::CLAMP_W-1:0] clamp_coord(
        input logic [btsmp_pkg::COORD_W-1:0] raw
    );
        logic [btsmp_pkg::CLAMP_W-1:0] res;
        if (raw[btsmp_pkg::COORD_W-1]) begin
            res = '0;
        end else if (raw[btsmp_pkg::CLAMP_W-1:0] > btsmp_pkg::COORD_ONE) begin
            res = btsmp_pkg::COORD_ONE;
        end else begin
            res = raw[btsmp_pkg::CLAMP_W-1:0];
        end
        return res;
    endfunction

    always_comb begin
        cu     = clamp_coord(i_u_coord);
        cv     = clamp_coord(i_v_coord);
        xm1    = XW'(i_size_x - 1'b1);
        ym1    = YW'(i_size_y - 1'b1);
        // coordinate times (size - 1), 16 fraction bits
        n_sc_x = SCX'(cu) * SCX'(xm1);
        n_sc_y = SCY'(cv) * SCY'(ym1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_item <= {i_command, i_texel_index, i_texel, n_sc_x, n_sc_y};
        end
    end

    assign o_push = r_vld;
    assign o_item = r_item;

endmodule

// File: src/btsmp_queue.sv
module btsmp_queue #(
    parameter int DATA_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_vld,
    output logic [DATA_W-1:0] o_data,
    output logic              o_full
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wptr;
    logic              r_rptr;
    logic [1:0]        r_count;
    logic              do_push;
    logic              do_pop;

    // the back end drains one word every cycle it has one
    assign do_pop  = (r_count != 2'd0);
    assign do_push = i_push && (r_count != 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_vld  = do_pop;
    assign o_data = r_mem[r_rptr];
    assign o_full = (r_count == 2'd2);

endmodule

// File: src/btsmp_back.sv
module btsmp_back #(
    parameter int MAX_WIDTH   = btsmp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = btsmp_pkg::DEF_MAX_HEIGHT,
    parameter int WEIGHT_BITS = btsmp_pkg::DEF_WEIGHT_BITS,
    parameter int ITEM_W      = 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_vld,
    input  logic [ITEM_W-1:0]               i_item,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]  i_size_x,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0] i_size_y,
    output logic                            o_valid,
    output logic [btsmp_pkg::OUT_W-1:0]     o_red,
    output logic [btsmp_pkg::OUT_W-1:0]     o_green,
    output logic [btsmp_pkg::OUT_W-1:0]     o_blue
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int SWX   = $clog2(MAX_WIDTH+1);
    localparam int SWY   = $clog2(MAX_HEIGHT+1);
    localparam int SCX   = btsmp_pkg::CLAMP_W + XW;
    localparam int SCY   = btsmp_pkg::CLAMP_W + YW;
    localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(STORE);
    localparam int RW    = YW + SWX + 1;
    localparam int WB    = WEIGHT_BITS;
    localparam int WW    = 2 * WB + 2;
    localparam int PWD   = WW + btsmp_pkg::CHAN_W;
    localparam int SUMW  = PWD + 2;
    localparam int TW    = btsmp_pkg::TEXEL_W;
    localparam int CW    = btsmp_pkg::CHAN_W;
    localparam logic [WB:0] W_ONE = (WB+1)'(1) << WB;

    logic                            cmd;
    logic [btsmp_pkg::INDEX_W-1:0]   widx;
    logic [TW-1:0]                   wdata;
    logic [SCX-1:0]                  sc_x;
    logic [SCY-1:0]                  sc_y;
    logic [XW-1:0]                   x0;
    logic [XW-1:0]                   x1;
    logic [YW-1:0]                   y0;
    logic [YW-1:0]                   y1;
    logic [WB:0]                     s;
    logic [WB:0]                     t;
    logic [RW-1:0]                   row0;
    logic [RW-1:0]                   row1;
    logic [AW-1:0]                   addr [4];
    logic [WW-1:0]                   n_w [4];
    logic                            wr_en;
    logic [AW-1:0]                   waddr;
    logic                            smp;

    logic                            r_v1;
    logic [TW-1:0]                   r_rd [4];
    logic [WW-1:0]                   r_w [4];
    logic                            r_v2;
    logic [PWD-1:0]                  r_p [3][4];
    logic                            r_v3;
    logic [btsmp_pkg::OUT_W-1:0]     r_out [3];
    logic [SUMW+CW-1:0]              n_scaled [3];

    always_comb begin
        {cmd, widx, wdata, sc_x, sc_y} = i_item;
        smp = i_vld && (cmd == btsmp_pkg::CMD_SAMPLE);
        // left/top texel, next one clamped at the edge
        x0 = sc_x[btsmp_pkg::COORD_FRAC +: XW];
        y0 = sc_y[btsmp_pkg::COORD_FRAC +: YW];
        x1 = ((SWX'(x0) + 1'b1) < i_size_x) ? XW'(x0 + 1'b1) : x0;
        y1 = ((SWY'(y0) + 1'b1) < i_size_y) ? YW'(y0 + 1'b1) : y0;
        s  = {1'b0, sc_x[btsmp_pkg::COORD_FRAC-1 -: WB]};
        t  = {1'b0, sc_y[btsmp_pkg::COORD_FRAC-1 -: WB]};
        row0 = RW'(y0) * RW'(i_size_x);
        row1 = RW'(y1) * RW'(i_size_x);
        addr[0] = AW'(row0 + RW'(x0));
        addr[1] = AW'(row0 + RW'(x1));
        addr[2] = AW'(row1 + RW'(x0));
        addr[3] = AW'(row1 + RW'(x1));
        n_w[0] = WW'(W_ONE - s) * WW'(W_ONE - t);
        n_w[1] = WW'(s) * WW'(W_ONE - t);
        n_w[2] = WW'(W_ONE - s) * WW'(t);
        n_w[3] = WW'(s) * WW'(t);
        wr_en = i_vld && (cmd == btsmp_pkg::CMD_LOAD) && (32'(widx) < 32'(STORE));
        waddr = AW'(32'(widx));
    end

    // four copies of the texel store, one read port each
    for (genvar k = 0; k < 4; k++) begin : g_copy
        logic [TW-1:0] mem [STORE];
        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                mem[waddr] <= wdata;
            end
            r_rd[k] <= mem[addr[k]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= smp;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_w[k] <= n_w[k];
        end
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < 4; k++) begin
                r_p[ch][k] <= PWD'(r_w[k]) * PWD'(r_rd[k][TW-1-CW*ch -: CW]);
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            r_out[ch] <= n_scaled[ch][btsmp_pkg::OUT_W-1:0];
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            // sum times 256, weight fraction bits dropped
            n_scaled[ch] = {SUMW'(r_p[ch][0]) + SUMW'(r_p[ch][1])
                            + SUMW'(r_p[ch][2]) + SUMW'(r_p[ch][3]), {CW{1'b0}}} >> (2 * WB);
        end
    end

    assign o_valid = r_v3;
    assign o_red   = r_out[0];
    assign o_green = r_out[1];
    assign o_blue  = r_out[2];

endmodule

// File: src/bilinear_texture_sampler.sv
// Bilinear texture sampler, clamp to edge. A load word (command 0) writes one RGB texel at
// x + y*width; a sample word (command 1) returns one blended RGB result, each channel as
// byte times 256. One word is taken every clock; busy stays low in normal use. A sample's
// result strobes on o_valid exactly five cycles after its start edge and is never held, so
// the receiver must take it then. Loads make no result. The front stage clamps and scales
// the coordinates with one multiply per axis; the back end reads the four neighbor texels
// from four copies of the texel store, one read port each, in one cycle, then weights and
// sums them over two more stages. A texel must be loaded before any sample that reads
// it; width and height may only be written while no sample is in flight.
module bilinear_texture_sampler #(
    parameter int MAX_WIDTH   = btsmp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = btsmp_pkg::DEF_MAX_HEIGHT,
    parameter int WEIGHT_BITS = btsmp_pkg::DEF_WEIGHT_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_command,
    input  logic [btsmp_pkg::INDEX_W-1:0]        i_texel_index,
    input  logic [btsmp_pkg::CHAN_W-1:0]         i_texel_red,
    input  logic [btsmp_pkg::CHAN_W-1:0]         i_texel_green,
    input  logic [btsmp_pkg::CHAN_W-1:0]         i_texel_blue,
    input  logic signed [btsmp_pkg::COORD_W-1:0] i_u_coord,
    input  logic signed [btsmp_pkg::COORD_W-1:0] i_v_coord,
    output logic                                 o_valid,
    output logic [btsmp_pkg::OUT_W-1:0]          o_out_red,
    output logic [btsmp_pkg::OUT_W-1:0]          o_out_green,
    output logic [btsmp_pkg::OUT_W-1:0]          o_out_blue,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_index,
    input  logic [btsmp_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int YW     = $clog2(MAX_HEIGHT);
    localparam int SWX    = $clog2(MAX_WIDTH+1);
    localparam int SWY    = $clog2(MAX_HEIGHT+1);
    localparam int ITEM_W = 1 + btsmp_pkg::INDEX_W + btsmp_pkg::TEXEL_W
                            + 2 * btsmp_pkg::CLAMP_W + XW + YW;

    logic [btsmp_pkg::CFG_W-1:0] r_tex_width;
    logic [btsmp_pkg::CFG_W-1:0] r_tex_height;
    logic [31:0]                 wx32;
    logic [31:0]                 hy32;
    logic [SWX-1:0]              size_x;
    logic [SWY-1:0]              size_y;
    logic                        accept;
    logic                        push;
    logic [ITEM_W-1:0]           f_item;
    logic                        q_vld;
    logic [ITEM_W-1:0]           q_item;
    logic                        q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width  <= btsmp_pkg::CFG_SIZE_RESET;
            r_tex_height <= btsmp_pkg::CFG_SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                btsmp_pkg::CFG_TEX_WIDTH:  r_tex_width  <= i_cfg_data;
                btsmp_pkg::CFG_TEX_HEIGHT: r_tex_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero counts as one, oversize saturates
    always_comb begin
        wx32 = 32'(r_tex_width);
        hy32 = 32'(r_tex_height);
        if (wx32 == 32'd0) begin
            wx32 = 32'd1;
        end else if (wx32 > 32'(MAX_WIDTH)) begin
            wx32 = 32'(MAX_WIDTH);
        end
        if (hy32 == 32'd0) begin
            hy32 = 32'd1;
        end else if (hy32 > 32'(MAX_HEIGHT)) begin
            hy32 = 32'(MAX_HEIGHT);
        end
        size_x = wx32[SWX-1:0];
        size_y = hy32[SWY-1:0];
    end

    assign busy   = q_full;
    assign accept = start && !busy;

    btsmp_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .ITEM_W    (ITEM_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_command    (i_command),
        .i_texel_index(i_texel_index),
        .i_texel      ({i_texel_red, i_texel_green, i_texel_blue}),
        .i_u_coord    (i_u_coord),
        .i_v_coord    (i_v_coord),
        .i_size_x     (size_x),
        .i_size_y     (size_y),
        .o_push       (push),
        .o_item       (f_item)
    );

    btsmp_queue #(
        .DATA_W(ITEM_W)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (f_item),
        .o_vld  (q_vld),
        .o_data (q_item),
        .o_full (q_full)
    );

    btsmp_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .WEIGHT_BITS(WEIGHT_BITS),
        .ITEM_W     (ITEM_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (q_vld),
        .i_item  (q_item),
        .i_size_x(size_x),
        .i_size_y(size_y),
        .o_valid (o_valid),
        .o_red   (o_out_red),
        .o_green (o_out_green),
        .o_blue  (o_out_blue)
    );

endmodule

// File: src/btsmp_checker.sv
`include "bilinear_texture_sampler_defines.svh"

module btsmp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        i_command,
    input logic                        o_valid,
    input logic [btsmp_pkg::OUT_W-1:0] o_out_red,
    input logic [btsmp_pkg::OUT_W-1:0] o_out_green,
    input logic [btsmp_pkg::OUT_W-1:0] o_out_blue
);

    localparam int LAT = btsmp_pkg::PIPE_LATENCY;

    logic           smp_acc;
    logic           out_ok;
    logic [LAT-1:0] r_smp_hist;

    assign smp_acc = start && !busy && (i_command == btsmp_pkg::CMD_SAMPLE);
    assign out_ok  = (o_out_red <= btsmp_pkg::OUT_MAX) && (o_out_green <= btsmp_pkg::OUT_MAX)
                     && (o_out_blue <= btsmp_pkg::OUT_MAX);

    // sample accepts over the last few edges, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp_hist <= '0;
        end else begin
            r_smp_hist <= {r_smp_hist[LAT-2:0], smp_acc};
        end
    end

    `BTSMP_ASSERT_ALWAYS(a_never_busy, i_clk, i_rst_n, !busy)
    `BTSMP_ASSERT_IMPLY(a_out_range, i_clk, i_rst_n, o_valid, out_ok)
    `BTSMP_ASSERT_IMPLY(a_strobe_has_sample, i_clk, i_rst_n, o_valid, r_smp_hist[LAT-1])
    `BTSMP_ASSERT_IMPLY(a_sample_gives_strobe, i_clk, i_rst_n, r_smp_hist[LAT-1], o_valid)

endmodule

bind bilinear_texture_sampler btsmp_checker u_btsmp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_command  (i_command),
    .o_valid    (o_valid),
    .o_out_red  (o_out_red),
    .o_out_green(o_out_green),
    .o_out_blue (o_out_blue)
);

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int IW = btsmp_pkg::INDEX_W;
    localparam int CW = btsmp_pkg::CHAN_W;
    localparam int TW = btsmp_pkg::TEXEL_W;
    localparam int KW = btsmp_pkg::COORD_W;
    localparam int OW = btsmp_pkg::OUT_W;
    localparam int GW = btsmp_pkg::CFG_W;

    typedef struct {
        logic                 cmd;
        logic [IW-1:0]        idx;
        logic [CW-1:0]        red;
        logic [CW-1:0]        green;
        logic [CW-1:0]        blue;
        logic signed [KW-1:0] u;
        logic signed [KW-1:0] v;
    } t_tex_word;

    typedef struct {
        logic [OW-1:0] red;
        logic [OW-1:0] green;
        logic [OW-1:0] blue;
    } t_rgb_out;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_command = btsmp_pkg::CMD_LOAD;
    logic [IW-1:0]        i_texel_index = '0;
    logic [CW-1:0]        i_texel_red = '0;
    logic [CW-1:0]        i_texel_green = '0;
    logic [CW-1:0]        i_texel_blue = '0;
    logic signed [KW-1:0] i_u_coord = '0;
    logic signed [KW-1:0] i_v_coord = '0;
    logic                 o_valid;
    logic [OW-1:0]        o_out_red;
    logic [OW-1:0]        o_out_green;
    logic [OW-1:0]        o_out_blue;
    logic                 i_cfg_we = 1'b0;
    logic                 i_cfg_index = btsmp_pkg::CFG_TEX_WIDTH;
    logic [GW-1:0]        i_cfg_data = '0;

    bilinear_texture_sampler DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // scoreboard state
    t_tex_word        word_q[$];
    t_rgb_out         blend_q[$];
    logic [TW-1:0]    texels[0:65535];
    logic [GW-1:0]    width_reg = btsmp_pkg::CFG_SIZE_RESET;
    logic [GW-1:0]    height_reg = btsmp_pkg::CFG_SIZE_RESET;
    t_tex_word        cur;
    int               burst_left = 0;
    int               gap_left = 0;
    int               errors = 0;
    int               n_loads = 0;
    int               n_samples = 0;
    int               n_results = 0;
    int               idle_cycles = 0;

    function automatic int unsigned eff_size(logic [GW-1:0] r);
        if (r == 0) return 1;
        if (r > 256) return 256;
        return 32'(r);
    endfunction

    function automatic int unsigned clamp_coord(logic signed [KW-1:0] c);
        if (c[KW-1]) return 0;
        if (c > 65536) return 65536;
        return 32'(c);
    endfunction

    function automatic t_rgb_out blend(t_tex_word w);
        int unsigned wd, ht, su, sv, x0, x1, y0, y1, s, t;
        logic [TW-1:0] ta, tb_, tc, td;
        longint unsigned wa, wb, wc, wdd, sum;
        logic [OW-1:0] ch[3];
        t_rgb_out r;
        wd = eff_size(width_reg);
        ht = eff_size(height_reg);
        su = clamp_coord(w.u) * (wd - 1);
        sv = clamp_coord(w.v) * (ht - 1);
        x0 = su >> 16;
        x1 = (x0 + 1 < wd) ? x0 + 1 : x0;
        s = (su >> 8) & 32'hFF;
        y0 = sv >> 16;
        y1 = (y0 + 1 < ht) ? y0 + 1 : y0;
        t = (sv >> 8) & 32'hFF;
        ta = texels[IW'(x0 + y0 * wd)];
        tb_ = texels[IW'(x1 + y0 * wd)];
        tc = texels[IW'(x0 + y1 * wd)];
        td = texels[IW'(x1 + y1 * wd)];
        wa = 64'((256 - s) * (256 - t));
        wb = 64'(s * (256 - t));
        wc = 64'((256 - s) * t);
        wdd = 64'(s * t);
        for (int c = 0; c < 3; c++) begin
            sum = wa * 64'(ta[16-8*c +: 8]) + wb * 64'(tb_[16-8*c +: 8])
                + wc * 64'(tc[16-8*c +: 8]) + wdd * 64'(td[16-8*c +: 8]);
            ch[c] = OW'((sum << 8) >> 16);
        end
        r.red = ch[0];
        r.green = ch[1];
        r.blue = ch[2];
        return r;
    endfunction

    task automatic accept_word(t_tex_word w);
        if (w.cmd == btsmp_pkg::CMD_LOAD) begin
            texels[w.idx] = {w.red, w.green, w.blue};
            n_loads++;
        end else begin
            blend_q.push_back(blend(w));
            n_samples++;
        end
    endtask

    task automatic report_mismatch(string field, logic [OW-1:0] got, logic [OW-1:0] want);
        $display("MISMATCH result %0d %s: got %0d expected %0d", n_results, field, got, want);
        errors++;
    endtask

    // driver: bursts of words with random gaps
    always @(posedge i_clk) begin
        logic go;
        go = 1'b0;
        if (i_rst_n) begin
            if (start && !busy) accept_word(cur);
            if (start && busy) begin
                go = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (word_q.size() > 0) begin
                if (burst_left == 0) burst_left = $urandom_range(1, 40);
                cur = word_q.pop_front();
                i_command <= cur.cmd;
                i_texel_index <= cur.idx;
                i_texel_red <= cur.red;
                i_texel_green <= cur.green;
                i_texel_blue <= cur.blue;
                i_u_coord <= cur.u;
                i_v_coord <= cur.v;
                go = 1'b1;
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
        end
        start <= go;
    end

    // monitor: strobed results cannot be held off
    always @(posedge i_clk) begin
        t_rgb_out want;
        if (i_rst_n && o_valid) begin
            if (blend_q.size() == 0) begin
                $display("unexpected result %0d", n_results);
                errors++;
            end else begin
                want = blend_q.pop_front();
                if (o_out_red !== want.red) report_mismatch("red", o_out_red, want.red);
                if (o_out_green !== want.green)
                    report_mismatch("green", o_out_green, want.green);
                if (o_out_blue !== want.blue) report_mismatch("blue", o_out_blue, want.blue);
            end
            n_results++;
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n || i_cfg_we) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000) begin
            $display("timeout: %0d samples still pending", blend_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic t_tex_word load_word(int unsigned idx);
        t_tex_word w;
        w.cmd = btsmp_pkg::CMD_LOAD;
        w.idx = IW'(idx);
        w.red = CW'($urandom);
        w.green = CW'($urandom);
        w.blue = CW'($urandom);
        w.u = KW'($urandom);
        w.v = KW'($urandom);
        return w;
    endfunction

    function automatic t_tex_word sample_word(int u, int v);
        t_tex_word w;
        w = load_word(0);
        w.cmd = btsmp_pkg::CMD_SAMPLE;
        w.idx = IW'($urandom);
        w.u = KW'(u);
        w.v = KW'(v);
        return w;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(0, 5))
            0: return int'($urandom);
            1: return int'($urandom_range(65536, 131071));
            2: return -int'($urandom_range(1, 131072));
            default: return int'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic drain();
        wait (word_q.size() == 0 && !start && blend_q.size() == 0);
        repeat (btsmp_pkg::PIPE_LATENCY + 3) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [GW-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == btsmp_pkg::CFG_TEX_WIDTH) width_reg = val;
        else height_reg = val;
    endtask

    int phase_w[6] = '{256, 1, 0, 5, 511, 2};
    int phase_h[6] = '{1, 511, 3, 7, 0, 2};
    int coord_edges[8] = '{0, 65536, 65537, 131071, -1, -131072, 32768, 65535};

    initial begin
        int unsigned region;
        foreach (texels[i]) texels[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (phase_w[p]) begin
            drain();
            write_reg(btsmp_pkg::CFG_TEX_WIDTH, GW'(phase_w[p]));
            write_reg(btsmp_pkg::CFG_TEX_HEIGHT, GW'(phase_h[p]));
            region = eff_size(GW'(phase_w[p])) * eff_size(GW'(phase_h[p]));
            // fill the addressed region before any sample touches it
            for (int i = 0; i < region; i++) word_q.push_back(load_word(i));
            foreach (coord_edges[a])
                word_q.push_back(sample_word(coord_edges[a], coord_edges[7-a]));
            for (int i = 0; i < 40; i++) begin
                if ($urandom_range(0, 4) == 0)
                    word_q.push_back(load_word(($urandom_range(0, 7) == 0) ?
                                               $urandom : $urandom_range(0, region - 1)));
                else
                    word_q.push_back(sample_word(rand_coord(), rand_coord()));
            end
        end
        drain();
        $display("%0d loads and %0d samples over %0d size settings, %0d results checked",
                 n_loads, n_samples, $size(phase_w), n_results);
        if (errors == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

endmodule
